FILE: hw/rtl/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; used by hsvrgb_scale and hsv_to_rgb_converter_top.
package hsvrgb_pkg;

  localparam int PCT_W     = 7;
  localparam int HUE_W     = 12;
  localparam int FRAC_W    = 10;   // position within a sector, 0..599
  localparam int SECTOR_W  = 3;
  localparam int PROD_W    = 14;   // percent times percent
  localparam int LEVEL_W   = 23;   // levels in units of 1/60000 percent
  localparam int CFG_IDX_W = 4;

  localparam int NUM_SECTORS = 6;

  localparam logic [PCT_W-1:0]   PCT_MAX       = 7'd100;
  localparam logic [HUE_W-1:0]   SECTOR_TENTHS = 12'd600;
  localparam logic [15:0]        TOP_SCALE     = 16'd60000;
  localparam logic [9:0]         LOW_SCALE     = 10'd600;
  localparam logic [LEVEL_W-1:0] FULL_DENOM    = 23'd6000000;

  // Fraction bits kept beyond the output in the reciprocal estimate
  localparam int RECIP_SHIFT = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE      = 4'd1;

  // Stage enables of the output scaling pipeline
  typedef struct packed {
    logic mul_en;
    logic fix_en;
    logic out_en;
  } scl_ctrl_t;

endpackage

FILE: hw/rtl/hsvrgb_scale.sv
// Scales one level to fixed point: floor(level * 2^OUT_FRAC_BITS / 6000000).
// Three stages: reciprocal multiply, back-multiply, one-step correction.
// Depends on hsvrgb_pkg.
module hsvrgb_scale #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic                                  clk,
  input  hsvrgb_pkg::scl_ctrl_t                 ctrl,
  input  logic [hsvrgb_pkg::LEVEL_W-1:0]        level_in,
  output logic [OUT_FRAC_BITS:0]                level_out
);

  localparam int OW = OUT_FRAC_BITS + 1;
  localparam int MW = OUT_FRAC_BITS + 1;
  localparam int PW = hsvrgb_pkg::LEVEL_W + MW;
  localparam int WW = hsvrgb_pkg::LEVEL_W + OUT_FRAC_BITS + 1;
  localparam longint unsigned RECIP =
    (64'd1 << (OUT_FRAC_BITS + hsvrgb_pkg::RECIP_SHIFT)) / 64'd6000000;
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  logic [hsvrgb_pkg::LEVEL_W-1:0] x1;
  logic [PW-1:0]                  prod;
  logic [hsvrgb_pkg::LEVEL_W-1:0] x2;
  logic [OW-1:0]                  est;
  logic [WW-1:0]                  est_d;
  logic [OW-1:0]                  est_c;
  logic [WW-1:0]                  rem;

  // Estimate is the true quotient or one below it
  assign est_c = OW'(prod >> hsvrgb_pkg::RECIP_SHIFT);
  assign rem   = (WW'(x2) << OUT_FRAC_BITS) - est_d;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      x1   <= level_in;
      prod <= PW'(level_in) * PW'(RECIP_M);
    end
    if (ctrl.fix_en) begin
      x2    <= x1;
      est   <= est_c;
      est_d <= WW'(est_c) * WW'(hsvrgb_pkg::FULL_DENOM);
    end
    if (ctrl.out_en) begin
      level_out <= (rem >= WW'(hsvrgb_pkg::FULL_DENOM)) ? est + OW'(1) : est;
    end
  end

endmodule

FILE: hw/rtl/hsv_to_rgb_converter_top.sv
// HSV to RGB converter, top level. Takes one hue request per clock while the output is not
// stalled, and returns red, green and blue levels; with rgb_ready held high there are no
// bubbles. The pipeline has three arithmetic stages (sector split, products, ordering)
// followed by the three-stage reciprocal scaling of each channel. Each stage holds its
// own valid bit, so a stalled output only backs up as far as the first empty stage.
// The user writes saturation and value through the configuration port only while idle;
// the block does not enforce it. Depends on hsvrgb_pkg and hsvrgb_scale.
module hsv_to_rgb_converter_top #(
  parameter int OUT_FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsvrgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsvrgb_pkg::PCT_W-1:0]        cfg_data,
  input  logic                                hue_valid,
  output logic                                hue_ready,
  input  logic [hsvrgb_pkg::HUE_W-1:0]        hue_tenths,
  output logic                                rgb_valid,
  input  logic                                rgb_ready,
  output logic [OUT_FRAC_BITS:0]              red_level,
  output logic [OUT_FRAC_BITS:0]              green_level,
  output logic [OUT_FRAC_BITS:0]              blue_level
);

  localparam int NSTG   = 6;
  localparam int RISE_W = hsvrgb_pkg::PROD_W + hsvrgb_pkg::FRAC_W;
  localparam int LOW_W  = hsvrgb_pkg::PROD_W + 10;
  localparam int TOP_W  = hsvrgb_pkg::PCT_W + 16;

  logic [hsvrgb_pkg::PCT_W-1:0] sat_pct;
  logic [hsvrgb_pkg::PCT_W-1:0] val_pct;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // Stage 1 inputs
  logic [hsvrgb_pkg::PCT_W-1:0]    sat;
  logic [hsvrgb_pkg::PCT_W-1:0]    val;
  logic [hsvrgb_pkg::SECTOR_W-1:0] cnt;
  logic [hsvrgb_pkg::SECTOR_W-1:0] sec_c;
  logic [hsvrgb_pkg::HUE_W-1:0]    base;
  logic [hsvrgb_pkg::FRAC_W-1:0]   f_c;

  logic [hsvrgb_pkg::SECTOR_W-1:0] sec1;
  logic [hsvrgb_pkg::FRAC_W-1:0]   f1;
  logic [hsvrgb_pkg::PROD_W-1:0]   sv1;
  logic [hsvrgb_pkg::PROD_W-1:0]   dv1;
  logic [hsvrgb_pkg::PCT_W-1:0]    v1;

  logic [RISE_W-1:0] rise_full;
  logic [LOW_W-1:0]  low_full;
  logic [TOP_W-1:0]  top_full;

  logic [hsvrgb_pkg::SECTOR_W-1:0] sec2;
  logic [hsvrgb_pkg::LEVEL_W-1:0]  rise2;
  logic [hsvrgb_pkg::LEVEL_W-1:0]  low2;
  logic [hsvrgb_pkg::LEVEL_W-1:0]  top2;

  logic [hsvrgb_pkg::LEVEL_W-1:0] inc;
  logic [hsvrgb_pkg::LEVEL_W-1:0] dec;
  logic [hsvrgb_pkg::LEVEL_W-1:0] r_c, g_c, b_c;
  logic [hsvrgb_pkg::LEVEL_W-1:0] r3, g3, b3;

  hsvrgb_pkg::scl_ctrl_t scl_ctrl;

  // Configuration
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_pct <= hsvrgb_pkg::PCT_MAX;
      val_pct <= hsvrgb_pkg::PCT_MAX;
    end else if (cfg_valid) begin
      if (cfg_index == hsvrgb_pkg::CFG_SATURATION) begin
        sat_pct <= cfg_data;
      end else if (cfg_index == hsvrgb_pkg::CFG_VALUE) begin
        val_pct <= cfg_data;
      end
    end
  end

  // Per-stage flow control: a stage loads when empty or when it moves on
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || rgb_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign hue_ready = adv[0] && !rst;
  assign rgb_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= hue_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: clamp, sector split, percent products
  assign sat = (sat_pct > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : sat_pct;
  assign val = (val_pct > hsvrgb_pkg::PCT_MAX) ? hsvrgb_pkg::PCT_MAX : val_pct;

  always_comb begin
    cnt = '0;
    for (int i = 1; i <= hsvrgb_pkg::NUM_SECTORS; i++) begin
      if (hue_tenths >= hsvrgb_pkg::HUE_W'(i * 600)) begin
        cnt = cnt + hsvrgb_pkg::SECTOR_W'(1);
      end
    end
  end

  // Hues past 359.9 degrees wrap to the first sector
  assign base  = hsvrgb_pkg::HUE_W'(cnt) * hsvrgb_pkg::SECTOR_TENTHS;
  assign f_c   = hsvrgb_pkg::FRAC_W'(hue_tenths - base);
  assign sec_c = (cnt == hsvrgb_pkg::SECTOR_W'(hsvrgb_pkg::NUM_SECTORS)) ? '0 : cnt;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sec1 <= sec_c;
      f1   <= f_c;
      sv1  <= hsvrgb_pkg::PROD_W'(sat) * hsvrgb_pkg::PROD_W'(val);
      dv1  <= hsvrgb_pkg::PROD_W'(hsvrgb_pkg::PCT_MAX - sat) * hsvrgb_pkg::PROD_W'(val);
      v1   <= val;
    end
  end

  // Stage 2: levels in units of 1/60000 percent
  assign rise_full = RISE_W'(sv1) * RISE_W'(f1);
  assign low_full  = LOW_W'(dv1) * LOW_W'(hsvrgb_pkg::LOW_SCALE);
  assign top_full  = TOP_W'(v1) * TOP_W'(hsvrgb_pkg::TOP_SCALE);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sec2  <= sec1;
      rise2 <= hsvrgb_pkg::LEVEL_W'(rise_full);
      low2  <= hsvrgb_pkg::LEVEL_W'(low_full);
      top2  <= hsvrgb_pkg::LEVEL_W'(top_full);
    end
  end

  // Stage 3: ramp levels and channel ordering
  assign inc = low2 + rise2;
  assign dec = top2 - rise2;

  always_comb begin
    case (sec2)
      3'd0: begin
        r_c = top2; g_c = inc;  b_c = low2;
      end
      3'd1: begin
        r_c = dec;  g_c = top2; b_c = low2;
      end
      3'd2: begin
        r_c = low2; g_c = top2; b_c = inc;
      end
      3'd3: begin
        r_c = low2; g_c = dec;  b_c = top2;
      end
      3'd4: begin
        r_c = inc;  g_c = low2; b_c = top2;
      end
      default: begin
        r_c = top2; g_c = low2; b_c = dec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      r3 <= r_c;
      g3 <= g_c;
      b3 <= b_c;
    end
  end

  // Stages 4 to 6: fixed-point scaling per channel
  assign scl_ctrl.mul_en = adv[3];
  assign scl_ctrl.fix_en = adv[4];
  assign scl_ctrl.out_en = adv[5];

  hsvrgb_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale_red (
    .clk       (clk),
    .ctrl      (scl_ctrl),
    .level_in  (r3),
    .level_out (red_level)
  );

  hsvrgb_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale_green (
    .clk       (clk),
    .ctrl      (scl_ctrl),
    .level_in  (g3),
    .level_out (green_level)
  );

  hsvrgb_scale #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_scale_blue (
    .clk       (clk),
    .ctrl      (scl_ctrl),
    .level_in  (b3),
    .level_out (blue_level)
  );

endmodule
